// ===== rtl/pmq_pkg.sv =====
package pmq_pkg;

	localparam int VALUE_W    = 32;
	localparam int SLOT_W     = 7;   // total_slots register and all pointers
	localparam int QCNT_W     = 4;   // queue_count register
	localparam int CNT_W      = 5;   // live queue count, holds up to 31
	localparam int QIDX_W     = 4;   // queue index in the pointer table
	localparam int QSEL_W     = 3;   // queue_index field
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SLOTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_COUNT = 2'd1;

	localparam logic FN_ENQ = 1'b0;
	localparam logic FN_DEQ = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_BAD_IDX = 2'd3;

	localparam logic [SLOT_W-1:0] RST_TOTAL_SLOTS = 7'd64;
	localparam logic [QCNT_W-1:0] RST_QUEUE_COUNT = 4'd8;

	localparam logic signed [VALUE_W-1:0] NONE_VALUE = -32'sd1;

	typedef struct packed {
		logic                      func;
		logic [QSEL_W-1:0]         queue_index;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [1:0]                status;
	} result_t;

	// wr is one past the last written slot; limit is the end of the partition
	typedef struct packed {
		logic [SLOT_W-1:0] limit;
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] wr;
	} ptr_entry_t;

	typedef struct packed {
		logic              en;
		logic [QIDX_W-1:0] idx;
		ptr_entry_t        entry;
	} init_wr_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] live;
	} setup_stat_t;

endpackage

// ===== rtl/pmq_setup.sv =====
module pmq_setup
	import pmq_pkg::*;
#(
	parameter int STORE_DEPTH = 64,
	parameter int MAX_QUEUES  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output init_wr_t              init_wr,
	output setup_stat_t           stat
);

	localparam logic [1:0] S_LOAD  = 2'd0;
	localparam logic [1:0] S_DIV   = 2'd1;
	localparam logic [1:0] S_SWEEP = 2'd2;
	localparam logic [1:0] S_IDLE  = 2'd3;

	localparam logic [2:0]       STEP_LAST  = 3'(SLOT_W - 1);
	localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(MAX_QUEUES - 1);

	logic [1:0]        state_q;
	logic [SLOT_W-1:0] slots_q;
	logic [QCNT_W-1:0] qcount_q;
	logic [CNT_W-1:0]  live_q;
	logic [SLOT_W-1:0] dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [2:0]        step_q;
	logic [SLOT_W-1:0] psize_q;
	logic [CNT_W-1:0]  idx_q;
	logic [SLOT_W-1:0] base_q;

	logic [SLOT_W-1:0] slots_eff;
	logic [CNT_W-1:0]  live_eff;
	logic [CNT_W-1:0]  rem_sh;
	logic              ge;
	logic [CNT_W-1:0]  rem_nx;
	logic [SLOT_W-1:0] dvd_nx;

	always_comb begin
		slots_eff = (32'(slots_q) > 32'(STORE_DEPTH)) ? SLOT_W'(STORE_DEPTH) : slots_q;
		live_eff  = (32'(qcount_q) > 32'(MAX_QUEUES)) ? CNT_W'(MAX_QUEUES)
		                                              : CNT_W'(qcount_q);
		// restoring divide, one quotient bit per cycle
		rem_sh = {rem_q[CNT_W-2:0], dvd_q[SLOT_W-1]};
		ge     = rem_sh >= live_q;
		rem_nx = ge ? rem_sh - live_q : rem_sh;
		dvd_nx = {dvd_q[SLOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			slots_q  <= RST_TOTAL_SLOTS;
			qcount_q <= RST_QUEUE_COUNT;
			live_q   <= '0;
			dvd_q    <= '0;
			rem_q    <= '0;
			step_q   <= '0;
			idx_q    <= '0;
			psize_q  <= '0;
			base_q   <= '0;
		end else if (cfg_wr && (cfg_index == REG_TOTAL_SLOTS ||
				cfg_index == REG_QUEUE_COUNT)) begin
			unique case (cfg_index)
				REG_TOTAL_SLOTS: slots_q  <= cfg_data;
				REG_QUEUE_COUNT: qcount_q <= cfg_data[QCNT_W-1:0];
				default: ;
			endcase
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					dvd_q   <= slots_eff;
					live_q  <= live_eff;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dvd_q  <= dvd_nx;
					rem_q  <= rem_nx;
					step_q <= step_q + 3'd1;
					if (step_q == STEP_LAST) begin
						psize_q <= (live_q == '0) ? '0 : dvd_nx;
						idx_q   <= '0;
						base_q  <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					base_q <= base_q + psize_q;
					idx_q  <= idx_q + CNT_W'(1);
					if (idx_q == SWEEP_LAST)
						state_q <= S_IDLE;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		init_wr.en          = state_q == S_SWEEP;
		init_wr.idx         = QIDX_W'(idx_q);
		init_wr.entry.head  = base_q;
		init_wr.entry.wr    = base_q;
		init_wr.entry.limit = base_q + psize_q;
		stat.busy           = state_q != S_IDLE;
		stat.live           = live_q;
	end

endmodule

// ===== rtl/pmq_engine.sv =====
module pmq_engine
	import pmq_pkg::*;
#(
	parameter int STORE_DEPTH = 64,
	parameter int MAX_QUEUES  = 8,
	parameter int DATA_WIDTH  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  cmd_t             cmd,
	input  init_wr_t         init_wr,
	input  logic [CNT_W-1:0] live,
	output logic             pending,
	output logic             done,
	output result_t          result
);

	localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	ptr_entry_t            ptr_mem   [MAX_QUEUES];
	logic [DATA_WIDTH-1:0] store_mem [STORE_DEPTH];

	logic       v_s1;
	cmd_t       cmd_s1;
	logic       bad_s1;
	ptr_entry_t ptr_s1;

	logic                  v_s2;
	logic [1:0]            st_s2;
	logic                  hit_s2;
	logic [DATA_WIDTH-1:0] rd_s2;

	logic       full, empty, enq_ok, deq_ok;
	logic [1:0] st;
	ptr_entry_t upd;

	always_comb begin
		full   = ptr_s1.wr == ptr_s1.limit;
		empty  = ptr_s1.head >= ptr_s1.wr;
		enq_ok = !bad_s1 && cmd_s1.func == FN_ENQ && !full;
		deq_ok = !bad_s1 && cmd_s1.func == FN_DEQ && !empty;
		priority if (bad_s1)                 st = ST_BAD_IDX;
		else if (cmd_s1.func == FN_ENQ && full) st = ST_FULL;
		else if (cmd_s1.func == FN_DEQ && empty) st = ST_EMPTY;
		else                                  st = ST_OK;
		upd = ptr_s1;
		if (enq_ok)
			upd.wr = ptr_s1.wr + SLOT_W'(1);
		if (deq_ok)
			upd.head = ptr_s1.head + SLOT_W'(1);
	end

	// pointer table: sweep writes during setup, read-modify-write per item
	always_ff @(posedge clk) begin
		if (init_wr.en)
			ptr_mem[QW'(init_wr.idx)] <= init_wr.entry;
		else if (v_s1 && (enq_ok || deq_ok))
			ptr_mem[QW'(cmd_s1.queue_index)] <= upd;
		if (accept)
			ptr_s1 <= ptr_mem[QW'(cmd.queue_index)];
	end

	always_ff @(posedge clk) begin
		if (v_s1 && enq_ok)
			store_mem[AW'(ptr_s1.wr)] <= DATA_WIDTH'(cmd_s1.value);
		rd_s2 <= store_mem[AW'(ptr_s1.head)];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			bad_s1 <= CNT_W'(cmd.queue_index) >= live;
		end
		if (v_s1) begin
			st_s2  <= st;
			hit_s2 <= deq_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		pending           = v_s1;
		done              = v_s2;
		result.read_value = hit_s2 ? VALUE_W'(rd_s2) : NONE_VALUE;
		result.status     = st_s2;
	end

endmodule

// ===== rtl/partitioned_multi_queue.sv =====
// An accepted start passes through the pending and done stages; busy holds off a new
// operation while one is pending, for the read-modify-write of the pointer table.
// Results are strobed for one cycle on done; the receiver cannot stall.
// After reset and after every write to total_slots or queue_count, busy stays high
// while the partition size is divided out and the pointer table is swept.
// Store contents are not cleared; only pointers are re-initialized.
module partitioned_multi_queue
	import pmq_pkg::*;
#(
	parameter int STORE_DEPTH = 64,
	parameter int MAX_QUEUES  = 8,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output result_t               result
);

	init_wr_t    init_wr;
	setup_stat_t stat;
	logic        pending;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign busy      = stat.busy || pending;
	assign accept    = start && !busy;

	pmq_setup #(
		.STORE_DEPTH(STORE_DEPTH),
		.MAX_QUEUES (MAX_QUEUES)
	) u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.init_wr  (init_wr),
		.stat     (stat)
	);

	pmq_engine #(
		.STORE_DEPTH(STORE_DEPTH),
		.MAX_QUEUES (MAX_QUEUES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.init_wr(init_wr),
		.live   (stat.live),
		.pending(pending),
		.done   (done),
		.result (result)
	);

endmodule

// ===== rtl/pmq_checker.sv =====
module pmq_checker
	import pmq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic                  done,
	input result_t               result
);

	// every accepted transaction must be followed by a result on done
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("missing result after accepted transaction");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.read_value == NONE_VALUE)
		else $error("failed operation returned data");

	a_cfg_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready &&
		(cfg_index == REG_TOTAL_SLOTS || cfg_index == REG_QUEUE_COUNT) |=> busy)
		else $error("register write did not start re-initialization");

endmodule

bind partitioned_multi_queue pmq_checker u_pmq_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import pmq_pkg::*;

	localparam int STORE_SLOTS = 64;
	localparam int QUEUE_LIMIT = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_OPS   = 128;

	class multi_queue_scoreboard;
		int slots_reg;
		int qcount_reg;
		int live;
		int part_size;
		int head_ptr[QUEUE_LIMIT];
		int tail_ptr[QUEUE_LIMIT];
		logic signed [VALUE_W-1:0] words[STORE_SLOTS];
		result_t due_results[$];
		int errors;

		function new();
			slots_reg  = int'(RST_TOTAL_SLOTS);
			qcount_reg = int'(RST_QUEUE_COUNT);
			errors     = 0;
			repartition();
		endfunction

		// every total_slots or queue_count write rebuilds all pointers; store words are kept
		function void repartition();
			int slots;
			slots     = (slots_reg > STORE_SLOTS) ? STORE_SLOTS : slots_reg;
			live      = (qcount_reg > QUEUE_LIMIT) ? QUEUE_LIMIT : qcount_reg;
			part_size = (live == 0) ? 0 : slots / live;
			for (int q = 0; q < QUEUE_LIMIT; q++) begin
				head_ptr[q] = q * part_size;
				tail_ptr[q] = q * part_size - 1;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_TOTAL_SLOTS) begin
				slots_reg = int'(data);
				repartition();
			end else if (idx == REG_QUEUE_COUNT) begin
				qcount_reg = int'(data[QCNT_W-1:0]);
				repartition();
			end
		endfunction

		function void predict(cmd_t c);
			result_t r;
			int q;
			q            = int'(c.queue_index);
			r.read_value = NONE_VALUE;
			r.status     = ST_OK;
			if (q >= live) begin
				r.status = ST_BAD_IDX;
			end else if (c.func == FN_ENQ) begin
				// linear queue: full once the tail hits the partition end
				if (tail_ptr[q] == (q + 1) * part_size - 1) begin
					r.status = ST_FULL;
				end else begin
					tail_ptr[q]++;
					words[tail_ptr[q]] = c.value;
				end
			end else if (head_ptr[q] > tail_ptr[q]) begin
				r.status = ST_EMPTY;
			end else begin
				r.read_value = words[head_ptr[q]];
				head_ptr[q]++;
			end
			due_results.push_back(r);
		endfunction

		task check(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result with nothing pending: read_value %0d status %0d",
					got.read_value, got.status));
				return;
			end
			want = due_results.pop_front();
			if (got.read_value !== want.read_value)
				report($sformatf("read_value %0d, expected %0d",
					got.read_value, want.read_value));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
		endtask

		task report(string msg);
			errors++;
			if (errors <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	cmd_t                  cmd;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  done;
	result_t               result;

	multi_queue_scoreboard ledger;
	int gap_style;
	int cycles = 0;

	partitioned_multi_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) ledger.check(result);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** partitioned_multi_queue: FAILED **");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(logic f, int q, logic signed [VALUE_W-1:0] v);
		cmd_t c;
		c.func        = f;
		c.queue_index = QSEL_W'(q);
		c.value       = v;
		return c;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	// with start still high, so a zero-gap follow-up keeps it asserted
	task automatic issue_op(input cmd_t c);
		int gap;
		case (gap_style)
			0:       gap = 0;
			1:       gap = $urandom_range(0, 15);
			default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		ledger.predict(c);
		@(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		int gap;
		gap = $urandom_range(0, 15);
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(idx, data);
		@(negedge clk);
	endtask

	// drop start and wait for every outstanding transaction to complete
	task automatic settle();
		start <= 1'b0;
		while (ledger.due_results.size() != 0) @(negedge clk);
	endtask

	// mode 0: slots only, 1: queue count only, 2: both
	task automatic configure(input int mode, input logic [CFG_DATA_W-1:0] slots,
			input logic [CFG_DATA_W-1:0] qdata);
		settle();
		if (mode != 1) write_cfg(REG_TOTAL_SLOTS, slots);
		if (mode != 0) write_cfg(REG_QUEUE_COUNT, qdata);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int mode;
		int enq_pct;
		logic [CFG_DATA_W-1:0] slots;
		logic [CFG_DATA_W-1:0] qdata;
		cmd_t c;

		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		gap_style = 2;
		ledger    = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset partitioning: 8 queues of 8
		issue_op(make_cmd(FN_DEQ, 0, 0));
		issue_op(make_cmd(FN_ENQ, 0, 32'sh7FFFFFFF));
		issue_op(make_cmd(FN_ENQ, 7, 32'sh80000000));
		issue_op(make_cmd(FN_DEQ, 0, 0));
		issue_op(make_cmd(FN_DEQ, 7, 0));
		issue_op(make_cmd(FN_DEQ, 0, 0));

		// partitions of 2: fill, overflow, drain, then still full
		configure(2, 16, 8);
		issue_op(make_cmd(FN_ENQ, 3, -1));
		issue_op(make_cmd(FN_ENQ, 3, 0));
		issue_op(make_cmd(FN_ENQ, 3, 32'sh5A5A5A5A));
		issue_op(make_cmd(FN_DEQ, 3, 0));
		issue_op(make_cmd(FN_DEQ, 3, 0));
		issue_op(make_cmd(FN_DEQ, 3, 0));
		issue_op(make_cmd(FN_ENQ, 3, 32'sh12345678));

		// slots clipped to the store depth, three queues, out-of-range index
		configure(2, 127, 3);
		issue_op(make_cmd(FN_ENQ, 5, 32'sh0000BEEF));
		issue_op(make_cmd(FN_DEQ, 3, 0));
		issue_op(make_cmd(FN_ENQ, 2, 32'shA5A5A5A5));
		issue_op(make_cmd(FN_DEQ, 2, 0));

		// no queues at all
		configure(1, 0, 0);
		issue_op(make_cmd(FN_ENQ, 0, 32'sh00000001));
		issue_op(make_cmd(FN_DEQ, 0, 0));

		// count clipped to max, zero-size partitions
		configure(2, 5, 15);
		issue_op(make_cmd(FN_ENQ, 1, 32'sh00000002));
		issue_op(make_cmd(FN_DEQ, 1, 0));
		issue_op(make_cmd(FN_ENQ, 7, 32'sh00000003));

		for (int p = 0; p < 12; p++) begin
			mode = 2;
			case (p)
				0: begin slots = 64;  qdata = 1;     end
				1: begin slots = 1;   qdata = 1;     end
				2: begin slots = 127; qdata = 7'h7F; end
				3: begin slots = 0;   qdata = 4;     end
				default: begin
					mode = $urandom_range(0, 2);
					case ($urandom_range(0, 19))
						0:       slots = 0;
						1, 2, 3: slots = CFG_DATA_W'($urandom_range(65, 127));
						default: slots = CFG_DATA_W'($urandom_range(1, 64));
					endcase
					case ($urandom_range(0, 9))
						0:       qdata = CFG_DATA_W'($urandom_range(0, 127));
						1:       qdata = CFG_DATA_W'($urandom_range(9, 15));
						default: qdata = CFG_DATA_W'($urandom_range(1, 8));
					endcase
				end
			endcase
			gap_style = $urandom_range(0, 2);
			configure(mode, slots, qdata);

			enq_pct = 50;
			for (int i = 0; i < PHASE_OPS; i++) begin
				// enqueue bias shifts every 16 ops to push queues to full and to empty
				if (i % 16 == 0) begin
					case ($urandom_range(0, 2))
						0:       enq_pct = 15;
						1:       enq_pct = 50;
						default: enq_pct = 85;
					endcase
				end
				c.func = ($urandom_range(0, 99) < enq_pct) ? FN_ENQ : FN_DEQ;
				if (ledger.live > 0 && $urandom_range(0, 9) != 0)
					c.queue_index = QSEL_W'($urandom_range(0, ledger.live - 1));
				else
					c.queue_index = QSEL_W'($urandom_range(0, 7));
				case ($urandom_range(0, 7))
					0:       c.value = 32'sh7FFFFFFF;
					1:       c.value = 32'sh80000000;
					default: c.value = $urandom;
				endcase
				issue_op(c);
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (ledger.errors == 0) begin
			$display("** partitioned_multi_queue: PASSED **");
		end else begin
			$display("** partitioned_multi_queue: FAILED **");
		end
		$finish;
	end

endmodule
